>>> design/spe_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// spe_pkg
// Shared types, constants and the microcode program of the sparse polynomial
// evaluator.
// ----------------------------------------------------------------------------
package spe_pkg;

  localparam int COEF_W  = 16;
  localparam int DEG_W   = 4;
  localparam int X_W     = 16;
  localparam int VAL_W   = 48;
  localparam int STAT_W  = 3;
  localparam int TOTAL_W = 5;
  localparam int P_W     = 48;
  localparam int PROD_W  = 64;
  localparam int UPC_W   = 5;

  // Saturation bounds of the power register and of the result (Q31.16).
  localparam logic signed [PROD_W-1:0] LIM_MAX = 64'sd140737488355327;
  localparam logic signed [PROD_W-1:0] LIM_MIN = -64'sd140737488355328;
  // Bound on the magnitude of a single term.
  localparam logic signed [PROD_W-1:0] TERM_MAX = 64'sd18014398509481984;
  localparam logic signed [PROD_W-1:0] TERM_MIN = -64'sd18014398509481984;
  localparam logic signed [P_W-1:0]    P_MAX    = 48'sh7FFF_FFFF_FFFF;
  localparam logic signed [P_W-1:0]    P_MIN    = 48'sh8000_0000_0000;
  localparam logic signed [P_W-1:0]    P_ONE    = 48'sd65536;

  typedef enum logic [1:0] {
    ACT_ADD    = 2'd0,
    ACT_REMOVE = 2'd1,
    ACT_EVAL   = 2'd2,
    ACT_NONE   = 2'd3
  } action_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK        = 3'd0,
    ST_DUPLICATE = 3'd1,
    ST_NOT_FOUND = 3'd2,
    ST_FULL      = 3'd3,
    ST_OVERFLOW  = 3'd4
  } status_t;

  typedef enum logic [3:0] {
    OP_NOP,
    OP_LATCH,
    OP_INC_IDX,
    OP_WRITE_NEW,
    OP_SET_DUP,
    OP_SET_NF,
    OP_SET_FULL,
    OP_SHIFT_WR,
    OP_DEC_COUNT,
    OP_LOAD_TERM,
    OP_MUL_LO,
    OP_MUL_HI,
    OP_POW_UPD,
    OP_ACC_TERM,
    OP_FINISH,
    OP_EMIT
  } op_t;

  typedef enum logic [3:0] {
    C_NEXT,
    C_ALWAYS,
    C_NO_START,
    C_ACT_EVAL,
    C_ACT_NONE,
    C_ACT_REM,
    C_IDX_END,
    C_MATCH,
    C_FULL,
    C_DCNT_ZERO
  } cond_t;

  typedef enum logic {
    B_X,
    B_COEF
  } bsel_t;

  typedef logic [UPC_W-1:0] upc_t;

  typedef struct packed {
    op_t   op;
    bsel_t bsel;
  } ctrl_t;

  typedef struct packed {
    ctrl_t ctrl;
    cond_t cond;
    upc_t  target;
  } ucw_t;

  typedef struct packed {
    logic act_eval;
    logic act_none;
    logic act_rem;
    logic idx_end;
    logic match;
    logic full;
    logic dcnt_zero;
  } flags_t;

  // Entry points of the program.
  localparam upc_t U_IDLE    = 5'd0;
  localparam upc_t U_DISP    = 5'd1;
  localparam upc_t U_DISP2   = 5'd2;
  localparam upc_t U_SRCH    = 5'd3;
  localparam upc_t U_SRCH2   = 5'd4;
  localparam upc_t U_SRCH3   = 5'd5;
  localparam upc_t U_NF      = 5'd6;
  localparam upc_t U_NF2     = 5'd7;
  localparam upc_t U_ADD     = 5'd8;
  localparam upc_t U_FULL    = 5'd9;
  localparam upc_t U_REM_NF  = 5'd10;
  localparam upc_t U_FOUND   = 5'd11;
  localparam upc_t U_DUP     = 5'd12;
  localparam upc_t U_REM     = 5'd13;
  localparam upc_t U_SHIFT   = 5'd14;
  localparam upc_t U_SHIFT2  = 5'd15;
  localparam upc_t U_REM_END = 5'd16;
  localparam upc_t U_EV_LOOP = 5'd17;
  localparam upc_t U_LOAD    = 5'd18;
  localparam upc_t U_POW     = 5'd19;
  localparam upc_t U_POW_LO  = 5'd20;
  localparam upc_t U_POW_HI  = 5'd21;
  localparam upc_t U_POW_UPD = 5'd22;
  localparam upc_t U_TERM    = 5'd23;
  localparam upc_t U_TERM_HI = 5'd24;
  localparam upc_t U_ACC     = 5'd25;
  localparam upc_t U_FIN     = 5'd26;
  localparam upc_t U_DONE    = 5'd27;

  function automatic ucw_t uw(input op_t op, input bsel_t bs, input cond_t c,
                              input upc_t t);
    ucw_t w;
    w.ctrl.op   = op;
    w.ctrl.bsel = bs;
    w.cond      = c;
    w.target    = t;
    return w;
  endfunction

  // The control store. A step whose condition holds jumps to its target,
  // otherwise the sequencer moves on to the next step.
  function automatic ucw_t ucode_rom(input upc_t a);
    ucw_t w;
    unique case (a)
      U_IDLE:    w = uw(OP_LATCH,     B_X,    C_NO_START,  U_IDLE);
      U_DISP:    w = uw(OP_NOP,       B_X,    C_ACT_EVAL,  U_EV_LOOP);
      U_DISP2:   w = uw(OP_NOP,       B_X,    C_ACT_NONE,  U_DONE);
      U_SRCH:    w = uw(OP_NOP,       B_X,    C_IDX_END,   U_NF);
      U_SRCH2:   w = uw(OP_NOP,       B_X,    C_MATCH,     U_FOUND);
      U_SRCH3:   w = uw(OP_INC_IDX,   B_X,    C_ALWAYS,    U_SRCH);
      U_NF:      w = uw(OP_NOP,       B_X,    C_ACT_REM,   U_REM_NF);
      U_NF2:     w = uw(OP_NOP,       B_X,    C_FULL,      U_FULL);
      U_ADD:     w = uw(OP_WRITE_NEW, B_X,    C_ALWAYS,    U_DONE);
      U_FULL:    w = uw(OP_SET_FULL,  B_X,    C_ALWAYS,    U_DONE);
      U_REM_NF:  w = uw(OP_SET_NF,    B_X,    C_ALWAYS,    U_DONE);
      U_FOUND:   w = uw(OP_NOP,       B_X,    C_ACT_REM,   U_REM);
      U_DUP:     w = uw(OP_SET_DUP,   B_X,    C_ALWAYS,    U_DONE);
      U_REM:     w = uw(OP_INC_IDX,   B_X,    C_NEXT,      U_IDLE);
      U_SHIFT:   w = uw(OP_NOP,       B_X,    C_IDX_END,   U_REM_END);
      U_SHIFT2:  w = uw(OP_SHIFT_WR,  B_X,    C_ALWAYS,    U_SHIFT);
      U_REM_END: w = uw(OP_DEC_COUNT, B_X,    C_ALWAYS,    U_DONE);
      U_EV_LOOP: w = uw(OP_NOP,       B_X,    C_IDX_END,   U_FIN);
      U_LOAD:    w = uw(OP_LOAD_TERM, B_X,    C_NEXT,      U_IDLE);
      U_POW:     w = uw(OP_NOP,       B_X,    C_DCNT_ZERO, U_TERM);
      U_POW_LO:  w = uw(OP_MUL_LO,    B_X,    C_NEXT,      U_IDLE);
      U_POW_HI:  w = uw(OP_MUL_HI,    B_X,    C_NEXT,      U_IDLE);
      U_POW_UPD: w = uw(OP_POW_UPD,   B_X,    C_ALWAYS,    U_POW);
      U_TERM:    w = uw(OP_MUL_LO,    B_COEF, C_NEXT,      U_IDLE);
      U_TERM_HI: w = uw(OP_MUL_HI,    B_COEF, C_NEXT,      U_IDLE);
      U_ACC:     w = uw(OP_ACC_TERM,  B_X,    C_ALWAYS,    U_EV_LOOP);
      U_FIN:     w = uw(OP_FINISH,    B_X,    C_NEXT,      U_IDLE);
      U_DONE:    w = uw(OP_EMIT,      B_X,    C_ALWAYS,    U_IDLE);
      default:   w = uw(OP_NOP,       B_X,    C_ALWAYS,    U_IDLE);
    endcase
    return w;
  endfunction

endpackage : spe_pkg
`default_nettype wire

>>> design/spe_useq.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// spe_useq
// Microcode sequencer: step counter, control store and jump logic.
// ----------------------------------------------------------------------------
module spe_useq
  import spe_pkg::*;
(
  input  wire    clk,
  input  wire    rst_n,
  input  wire    start,
  input  flags_t flags,
  output ctrl_t  ctrl,
  output logic   busy
);

  upc_t pc_r;
  upc_t pc_nxt;
  ucw_t ucw;
  logic taken;

  assign ucw  = ucode_rom(pc_r);
  assign ctrl = ucw.ctrl;
  assign busy = (pc_r != U_IDLE);

  always_comb begin
    unique case (ucw.cond)
      C_NEXT:      taken = 1'b0;
      C_ALWAYS:    taken = 1'b1;
      C_NO_START:  taken = !start;
      C_ACT_EVAL:  taken = flags.act_eval;
      C_ACT_NONE:  taken = flags.act_none;
      C_ACT_REM:   taken = flags.act_rem;
      C_IDX_END:   taken = flags.idx_end;
      C_MATCH:     taken = flags.match;
      C_FULL:      taken = flags.full;
      C_DCNT_ZERO: taken = flags.dcnt_zero;
      default:     taken = 1'b1;
    endcase
    pc_nxt = taken ? ucw.target : pc_r + upc_t'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r <= U_IDLE;
    end else begin
      pc_r <= pc_nxt;
    end
  end

endmodule : spe_useq
`default_nettype wire

>>> design/spe_dpath.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// spe_dpath
// Datapath: term memory, search index, power and product registers, two
// shared 24x16 multipliers, the accumulator and the result register.
// ----------------------------------------------------------------------------
module spe_dpath
  import spe_pkg::*;
#(
  parameter int MAX_TERMS = 16
)(
  input  wire                        clk,
  input  wire                        rst_n,
  input  ctrl_t                      ctrl,
  input  wire  [1:0]                 in_action,
  input  wire  signed [COEF_W-1:0]   in_coef_in,
  input  wire  [DEG_W-1:0]           in_degree_in,
  input  wire  signed [X_W-1:0]      in_x_value,
  output flags_t                     flags,
  output logic                       out_valid,
  output logic signed [VAL_W-1:0]    out_poly_value,
  output logic [STAT_W-1:0]          out_status,
  output logic [TOTAL_W-1:0]         out_term_total
);

  localparam int CW = $clog2(MAX_TERMS + 1);
  localparam int AW = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;

  // Term memory.
  logic signed [COEF_W-1:0] coef_mem [MAX_TERMS];
  logic [DEG_W-1:0]         deg_mem  [MAX_TERMS];
  logic                     mem_we;
  logic [AW-1:0]            wr_addr;
  logic signed [COEF_W-1:0] wr_coef;
  logic [DEG_W-1:0]         wr_deg;
  logic [CW-1:0]            idx_dec;
  logic signed [COEF_W-1:0] rd_coef_r;
  logic [DEG_W-1:0]         rd_deg_r;

  // Control state.
  logic [CW-1:0] count_r, count_nxt;
  logic          out_valid_r, out_valid_nxt;

  // Working registers.
  action_t                  act_r, act_nxt;
  logic signed [COEF_W-1:0] coef_r, coef_nxt;
  logic [DEG_W-1:0]         deg_r, deg_nxt;
  logic signed [X_W-1:0]    x_r, x_nxt;
  logic [CW-1:0]            idx_r, idx_nxt;
  logic signed [P_W-1:0]    p_r, p_nxt;
  logic [DEG_W-1:0]         dcnt_r, dcnt_nxt;
  logic signed [COEF_W-1:0] tcoef_r, tcoef_nxt;
  logic                     clamped_r, clamped_nxt;
  logic signed [PROD_W-1:0] prod_r, prod_nxt;
  logic signed [PROD_W-1:0] sum_r, sum_nxt;
  logic                     ovf_r, ovf_nxt;
  logic signed [VAL_W-1:0]  val_r, val_nxt;
  status_t                  st_r, st_nxt;
  logic signed [VAL_W-1:0]  oval_r, oval_nxt;
  status_t                  ost_r, ost_nxt;
  logic [TOTAL_W-1:0]       otot_r, otot_nxt;

  // Arithmetic.
  logic signed [COEF_W-1:0] b_op;
  logic signed [40:0]       mul_lo;
  logic signed [39:0]       mul_hi;
  logic signed [PROD_W-1:0] pq;
  logic signed [PROD_W-1:0] tcl;
  logic                     t_over;
  logic                     s_over;

  assign idx_dec = idx_r - CW'(1);
  assign mem_we  = (ctrl.op == OP_WRITE_NEW) || (ctrl.op == OP_SHIFT_WR);
  assign wr_addr = (ctrl.op == OP_WRITE_NEW) ? count_r[AW-1:0] : idx_dec[AW-1:0];
  assign wr_coef = (ctrl.op == OP_WRITE_NEW) ? coef_r : rd_coef_r;
  assign wr_deg  = (ctrl.op == OP_WRITE_NEW) ? deg_r : rd_deg_r;

  // The read port follows the index every cycle, so data for a new index
  // passes through idx_r and then the read registers before it is usable.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      coef_mem[wr_addr] <= wr_coef;
      deg_mem[wr_addr]  <= wr_deg;
    end
    rd_coef_r <= coef_mem[idx_r[AW-1:0]];
    rd_deg_r  <= deg_mem[idx_r[AW-1:0]];
  end

  // The power register is split at bit 24: the low half is taken as unsigned,
  // the high half as signed, and the two partial products are summed.
  assign b_op   = (ctrl.bsel == B_X) ? x_r : tcoef_r;
  assign mul_lo = $signed({1'b0, p_r[23:0]}) * b_op;
  assign mul_hi = $signed(p_r[47:24]) * b_op;
  assign pq     = prod_r >>> 8;

  always_comb begin
    t_over = 1'b1;
    if (prod_r > TERM_MAX) begin
      tcl = TERM_MAX;
    end else if (prod_r < TERM_MIN) begin
      tcl = TERM_MIN;
    end else begin
      tcl    = prod_r;
      t_over = 1'b0;
    end
  end

  assign s_over = ovf_r || (sum_r > LIM_MAX) || (sum_r < LIM_MIN);

  always_comb begin
    count_nxt     = count_r;
    out_valid_nxt = 1'b0;
    act_nxt       = act_r;
    coef_nxt      = coef_r;
    deg_nxt       = deg_r;
    x_nxt         = x_r;
    idx_nxt       = idx_r;
    p_nxt         = p_r;
    dcnt_nxt      = dcnt_r;
    tcoef_nxt     = tcoef_r;
    clamped_nxt   = clamped_r;
    prod_nxt      = prod_r;
    sum_nxt       = sum_r;
    ovf_nxt       = ovf_r;
    val_nxt       = val_r;
    st_nxt        = st_r;
    oval_nxt      = oval_r;
    ost_nxt       = ost_r;
    otot_nxt      = otot_r;
    unique case (ctrl.op)
      OP_NOP: begin
      end
      OP_LATCH: begin
        act_nxt  = action_t'(in_action);
        coef_nxt = in_coef_in;
        deg_nxt  = in_degree_in;
        x_nxt    = in_x_value;
        idx_nxt  = '0;
        sum_nxt  = '0;
        ovf_nxt  = 1'b0;
        val_nxt  = '0;
        st_nxt   = ST_OK;
      end
      OP_INC_IDX: begin
        idx_nxt = idx_r + CW'(1);
      end
      OP_WRITE_NEW: begin
        count_nxt = count_r + CW'(1);
      end
      OP_SET_DUP: begin
        st_nxt = ST_DUPLICATE;
      end
      OP_SET_NF: begin
        st_nxt = ST_NOT_FOUND;
      end
      OP_SET_FULL: begin
        st_nxt = ST_FULL;
      end
      OP_SHIFT_WR: begin
        idx_nxt = idx_r + CW'(1);
      end
      OP_DEC_COUNT: begin
        count_nxt = count_r - CW'(1);
      end
      OP_LOAD_TERM: begin
        p_nxt       = P_ONE;
        dcnt_nxt    = rd_deg_r;
        tcoef_nxt   = rd_coef_r;
        clamped_nxt = 1'b0;
      end
      OP_MUL_LO: begin
        prod_nxt = {{(PROD_W - 41){mul_lo[40]}}, mul_lo};
      end
      OP_MUL_HI: begin
        prod_nxt = prod_r + {mul_hi, 24'd0};
      end
      OP_POW_UPD: begin
        dcnt_nxt = dcnt_r - DEG_W'(1);
        if (pq > LIM_MAX) begin
          p_nxt       = P_MAX;
          clamped_nxt = 1'b1;
        end else if (pq < LIM_MIN) begin
          p_nxt       = P_MIN;
          clamped_nxt = 1'b1;
        end else begin
          p_nxt = pq[P_W-1:0];
        end
      end
      OP_ACC_TERM: begin
        sum_nxt = sum_r + tcl;
        ovf_nxt = ovf_r || t_over || (clamped_r && (tcoef_r != '0));
        idx_nxt = idx_r + CW'(1);
      end
      OP_FINISH: begin
        if (s_over) begin
          val_nxt = sum_r[PROD_W-1] ? P_MIN : P_MAX;
          st_nxt  = ST_OVERFLOW;
        end else begin
          val_nxt = sum_r[VAL_W-1:0];
        end
      end
      OP_EMIT: begin
        out_valid_nxt = 1'b1;
        oval_nxt      = val_r;
        ost_nxt       = st_r;
        otot_nxt      = TOTAL_W'(count_r);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    act_r     <= act_nxt;
    coef_r    <= coef_nxt;
    deg_r     <= deg_nxt;
    x_r       <= x_nxt;
    idx_r     <= idx_nxt;
    p_r       <= p_nxt;
    dcnt_r    <= dcnt_nxt;
    tcoef_r   <= tcoef_nxt;
    clamped_r <= clamped_nxt;
    prod_r    <= prod_nxt;
    sum_r     <= sum_nxt;
    ovf_r     <= ovf_nxt;
    val_r     <= val_nxt;
    st_r      <= st_nxt;
    oval_r    <= oval_nxt;
    ost_r     <= ost_nxt;
    otot_r    <= otot_nxt;
  end

  assign flags.act_eval  = (act_r == ACT_EVAL);
  assign flags.act_none  = (act_r == ACT_NONE);
  assign flags.act_rem   = (act_r == ACT_REMOVE);
  assign flags.idx_end   = (idx_r == count_r);
  assign flags.match     = (rd_deg_r == deg_r);
  assign flags.full      = (count_r == CW'(MAX_TERMS));
  assign flags.dcnt_zero = (dcnt_r == '0);

  assign out_valid      = out_valid_r;
  assign out_poly_value = oval_r;
  assign out_status     = ost_r;
  assign out_term_total = otot_r;

endmodule : spe_dpath
`default_nettype wire

>>> design/sparse_polynomial_evaluator.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sparse_polynomial_evaluator
// Term table with add, remove and evaluate requests, run by a microcoded
// sequencer over a memory-backed datapath.
// ----------------------------------------------------------------------------
// One request is taken when start is high and busy is low; busy then stays
// high until the result has been loaded, and exactly one result follows each
// request, shown for a single cycle with out_valid high. The receiver cannot
// stall, so it must capture the result in that cycle. Work is strictly one
// request at a time. Add and remove search the table with the steps U_SRCH,
// U_SRCH2 and U_SRCH3 for each stored term looked at, and a remove then
// shifts the later terms down with U_SHIFT and U_SHIFT2 for each. Evaluation
// loads each stored term, builds its power of x by repeated multiplication,
// one degree step at a time, and multiplies it by the coefficient; every
// power step and every term product goes through the low-half and then the
// high-half 24x16 multiplier. Degrees are distinct: an add of a degree that
// is already stored is refused as a duplicate.
// ----------------------------------------------------------------------------
module sparse_polynomial_evaluator
  import spe_pkg::*;
#(
  parameter int MAX_TERMS = 16
)(
  input  wire                       clk,
  input  wire                       rst_n,
  input  wire                       start,
  output logic                      busy,
  input  wire  [1:0]                in_action,
  input  wire  signed [COEF_W-1:0]  in_coef_in,
  input  wire  [DEG_W-1:0]          in_degree_in,
  input  wire  signed [X_W-1:0]     in_x_value,
  output logic                      out_valid,
  output logic signed [VAL_W-1:0]   out_poly_value,
  output logic [STAT_W-1:0]         out_status,
  output logic [TOTAL_W-1:0]        out_term_total
);

  ctrl_t  ctrl;
  flags_t flags;

  spe_useq u_useq (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .flags (flags),
    .ctrl  (ctrl),
    .busy  (busy)
  );

  spe_dpath #(
    .MAX_TERMS (MAX_TERMS)
  ) u_dpath (
    .clk            (clk),
    .rst_n          (rst_n),
    .ctrl           (ctrl),
    .in_action      (in_action),
    .in_coef_in     (in_coef_in),
    .in_degree_in   (in_degree_in),
    .in_x_value     (in_x_value),
    .flags          (flags),
    .out_valid      (out_valid),
    .out_poly_value (out_poly_value),
    .out_status     (out_status),
    .out_term_total (out_term_total)
  );

endmodule : sparse_polynomial_evaluator
`default_nettype wire
